// ===== rtl/lookahead_path_tracking_controller_defines.svh =====
// Assertion macros for the path tracking controller.
`ifndef LOOKAHEAD_PATH_TRACKING_CONTROLLER_DEFINES_SVH
`define LOOKAHEAD_PATH_TRACKING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define LPTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lptc check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define LPTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lptc check failed");

`endif

// ===== rtl/lptc_pkg.sv =====
// Shared types, codes and constants of the path tracking controller.
`timescale 1ns / 1ps
package lptc_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_CMD    = 2'd2;

    localparam logic [2:0] CFG_GOAL_TOL  = 3'd0;
    localparam logic [2:0] CFG_STOP_DIST = 3'd1;
    localparam logic [2:0] CFG_SLOW_DIST = 3'd2;
    localparam logic [2:0] CFG_LOOKAHEAD = 3'd3;
    localparam logic [2:0] CFG_FWD_GAIN  = 3'd4;
    localparam logic [2:0] CFG_TURN_GAIN = 3'd5;
    localparam logic [2:0] CFG_FWD_LIMIT = 3'd6;
    localparam logic [2:0] CFG_TURN_LIM  = 3'd7;

    // CORDIC datapath widths
    localparam int CW = 36;
    localparam int ZW = 24;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd1647099;
    localparam logic signed [25:0]   ANG_PI      = 26'sd3294199;
    localparam logic signed [25:0]   ANG_TWO_PI  = 26'sd6588398;
    localparam logic signed [CW-1:0] COS_GAIN    = 36'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic [49:0]          SQRT_TOP    = 50'h1_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GOAL, ST_CHECK, ST_SCAN1, ST_SCAN2, ST_SQRT_T, ST_SQRT_G,
        ST_BEAR, ST_ERR, ST_COSLD, ST_COS, ST_MULC, ST_SLOW, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic vec;   // 1: vectoring (drive y to 0), 0: rotation (drive z to 0)
    } t_cordic_ctl;

    // atan(2^-i) in 2^-20 rad
    function automatic logic [19:0] atan_val(input logic [4:0] idx);
        logic [19:0] v;
        case (idx)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lptc_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
`timescale 1ns / 1ps
module lptc_cordic
    import lptc_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_ctl          i_ctl,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_busy,
    output logic signed [CW-1:0] o_x,
    output logic signed [ZW-1:0] o_z
);
    localparam int SW = $clog2(STEPS);

    logic                 r_busy;
    logic [SW-1:0]        r_i;
    logic                 r_vec;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_a;
    logic                 w_neg;

    always_comb begin
        w_xs  = r_x >>> r_i;
        w_ys  = r_y >>> r_i;
        w_a   = ZW'({4'b0, atan_val(5'(r_i))});
        // vectoring with y < 0 and rotation with z >= 0 turn the same way
        w_neg = r_vec ? r_y[CW-1] : !r_z[ZW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_i == SW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_ctl.vec;
        end else if (r_busy) begin
            if (w_neg) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_a;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_a;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

// ===== rtl/lookahead_path_tracking_controller.sv =====
// Top level: path store, scan pipeline, sequencer and shared arithmetic.
// Clear and append give no result; busy stays low.
// Command: empty path answers the cycle after start; goal or obstacle stop answers once
// the goal point is scanned and checked; otherwise it follows two point scans (one point
// a cycle), two 25-step square roots, two CORDIC runs, a 49-step divider if obs < slow.
// Synchronous active-low reset: path empty, registers at defaults, idle.
`timescale 1ns / 1ps
`include "lookahead_path_tracking_controller_defines.svh"
module lookahead_path_tracking_controller
    import lptc_pkg::*;
#(
    parameter int PATH_DEPTH   = 128,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_robot_x,
    input  logic signed [23:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    input  logic [15:0]        i_obstacle_distance,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [15:0]        o_forward_speed,
    output logic signed [15:0] o_turn_rate,
    output logic               o_goal_reached,
    output logic               o_motion_blocked
);
    localparam int AW = $clog2(PATH_DEPTH);
    localparam int LW = $clog2(PATH_DEPTH + 1);

    t_state r_state, n_state;

    logic [15:0] r_goal_tol, r_stop, r_slow, r_la, r_fgain, r_tgain, r_flim;
    logic [14:0] r_tlim;
    logic [LW-1:0] r_len;

    logic signed [23:0] mem_x [PATH_DEPTH];
    logic signed [23:0] mem_y [PATH_DEPTH];

    logic signed [23:0] r_rx, r_ry;
    logic signed [15:0] r_head;
    logic [15:0]        r_obs;

    // scan pipeline
    logic [AW-1:0]      r_cnt, r_last;
    logic               r_issuing;
    logic               r_p0_v, r_p1_v, r_p2_v, r_p3_v;
    logic [AW-1:0]      r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx;
    logic signed [23:0] r_mx, r_my;
    logic signed [24:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic [47:0]        r_sqx, r_sqy;
    logic [48:0]        r_d2;

    logic [48:0]        r_gd2, r_best, r_td2;
    logic signed [24:0] r_gdx, r_gdy, r_tdx, r_tdy;
    logic [AW-1:0]      r_closest;
    logic               r_found;
    logic [31:0]        r_la2;

    logic [49:0] r_sq_v, r_sq_r, r_sq_bit;
    logic [24:0] r_tdist, r_gdist;

    logic               r_zero;
    logic signed [25:0] r_err;
    logic signed [17:0] r_err13;
    logic [32:0]        r_s1, r_s;
    logic [30:0]        r_cos;
    logic signed [15:0] r_turn;
    logic [15:0]        r_span, r_num;
    logic [48:0]        r_dq;
    logic [15:0]        r_drem;
    logic [5:0]         r_dcnt;

    t_cordic_ctl          s_ctl;
    logic signed [CW-1:0] w_cx, w_cy, c_x;
    logic signed [ZW-1:0] w_cz, c_z;
    logic                 c_busy;

    logic               w_accept, w_pipe_empty;
    logic [AW-1:0]      w_last_idx;
    logic signed [24:0] w_dx, w_dy;
    logic signed [49:0] w_sqx, w_sqy;
    logic [31:0]        w_tol2, w_la2;
    logic [49:0]        w_sq_t;
    logic signed [32:0] w_bx, w_by;
    logic signed [ZW-1:0] w_bear;
    logic signed [25:0] w_wrap, w_r64;
    logic [24:0]        w_dmin;
    logic [40:0]        w_s1;
    logic [63:0]        w_sc;
    logic [48:0]        w_prod;
    logic [16:0]        w_stop10, w_rem_sh;
    logic [15:0]        w_span, w_diff;
    logic signed [35:0] w_tprod, w_turn, w_tl;
    logic [48:0]        w_dq_next;
    logic [15:0]        w_rem_next;

    assign w_accept     = i_start && !o_busy;
    assign w_pipe_empty = !r_issuing && !r_p0_v && !r_p1_v && !r_p2_v && !r_p3_v;
    assign w_last_idx   = AW'(r_len - LW'(1));
    assign o_cfg_ready  = 1'b1;

    always_comb begin
        w_dx     = {r_mx[23], r_mx} - {r_rx[23], r_rx};
        w_dy     = {r_my[23], r_my} - {r_ry[23], r_ry};
        w_sqx    = r_dx1 * r_dx1;
        w_sqy    = r_dy1 * r_dy1;
        w_tol2   = r_goal_tol * r_goal_tol;
        w_la2    = r_la * r_la;
        w_sq_t   = r_sq_r + r_sq_bit;
        w_bx     = 33'({r_tdx, 8'b0});
        w_by     = 33'({r_tdy, 8'b0});
        w_bear   = r_zero ? '0 : c_z;
        w_wrap   = r_err;
        if (r_err > ANG_PI) begin
            w_wrap = r_err - ANG_TWO_PI;
        end else if (r_err <= -ANG_PI) begin
            w_wrap = r_err + ANG_TWO_PI;
        end
        w_r64    = (w_wrap + 26'sd64) >>> 7;
        w_dmin   = (r_tdist < r_gdist) ? r_tdist : r_gdist;
        w_s1     = r_fgain * w_dmin;
        w_sc     = r_s1 * r_cos;
        w_prod   = r_s * r_num;
        w_stop10 = {1'b0, r_stop} + 17'd10;
        w_span   = ({1'b0, r_slow} > w_stop10) ? (r_slow - r_stop) : 16'd10;
        w_diff   = r_obs - r_stop;
        w_tprod  = $signed({1'b0, r_tgain}) * r_err13 + 36'sd1024;
        w_turn   = w_tprod >>> 11;
        w_tl     = $signed({21'b0, r_tlim});
        w_rem_sh = {r_drem, r_dq[48]};
        if (w_rem_sh >= {1'b0, r_span}) begin
            w_rem_next = 16'(w_rem_sh - {1'b0, r_span});
            w_dq_next  = {r_dq[47:0], 1'b1};
        end else begin
            w_rem_next = w_rem_sh[15:0];
            w_dq_next  = {r_dq[47:0], 1'b0};
        end
    end

    // CORDIC operands: bearing with quarter-turn pre-rotation, or cosine
    always_comb begin
        if (r_state == ST_SQRT_G) begin
            w_cx = CW'(w_bx);
            w_cy = CW'(w_by);
            w_cz = '0;
            if (w_bx < 0) begin
                if (w_by >= 0) begin
                    w_cx = CW'(w_by);
                    w_cy = -CW'(w_bx);
                    w_cz = ANG_HALF_PI;
                end else begin
                    w_cx = -CW'(w_by);
                    w_cy = CW'(w_bx);
                    w_cz = -ANG_HALF_PI;
                end
            end
        end else begin
            w_cx = COS_GAIN;
            w_cy = '0;
            w_cz = ZW'(r_err13) <<< 7;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_operation == OP_CMD && r_len != '0) begin
                    n_state = ST_GOAL;
                end
            end
            ST_GOAL:   if (w_pipe_empty) n_state = ST_CHECK;
            ST_CHECK: begin
                if ({17'b0, w_tol2} >= r_gd2 || r_obs < r_stop) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN1;
                end
            end
            ST_SCAN1:  if (w_pipe_empty) n_state = ST_SCAN2;
            ST_SCAN2:  if (w_pipe_empty) n_state = ST_SQRT_T;
            ST_SQRT_T: if (r_sq_bit == '0) n_state = ST_SQRT_G;
            ST_SQRT_G: if (r_sq_bit == '0) n_state = ST_BEAR;
            ST_BEAR:   if (!c_busy) n_state = ST_ERR;
            ST_ERR:    n_state = ST_COSLD;
            ST_COSLD:  n_state = ST_COS;
            ST_COS:    if (!c_busy) n_state = ST_MULC;
            ST_MULC:   n_state = ST_SLOW;
            ST_SLOW:   n_state = (r_obs < r_slow) ? ST_DIV : ST_OUT;
            ST_DIV:    if (r_dcnt == 6'd48) n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ctl.load = (r_state == ST_SQRT_G && r_sq_bit == '0) || r_state == ST_COSLD;
        s_ctl.vec  = (r_state == ST_SQRT_G);
        o_busy     = (r_state != ST_IDLE);
    end

    lptc_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (s_ctl),
        .i_x    (w_cx),
        .i_y    (w_cy),
        .i_z    (w_cz),
        .o_busy (c_busy),
        .o_x    (c_x),
        .o_z    (c_z)
    );

    // path store
    always_ff @(posedge i_clk) begin
        if (w_accept && i_operation == OP_APPEND && r_len < LW'(PATH_DEPTH)) begin
            mem_x[AW'(r_len)] <= i_point_x;
            mem_y[AW'(r_len)] <= i_point_y;
        end
        r_mx <= mem_x[r_cnt];
        r_my <= mem_y[r_cnt];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_goal_tol <= 16'd205;
            r_stop     <= 16'd307;
            r_slow     <= 16'd819;
            r_la       <= 16'd512;
            r_fgain    <= 16'd128;
            r_tgain    <= 16'd256;
            r_flim     <= 16'd512;
            r_tlim     <= 15'd1024;
            r_issuing  <= 1'b0;
            r_p0_v     <= 1'b0;
            r_p1_v     <= 1'b0;
            r_p2_v     <= 1'b0;
            r_p3_v     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            r_p0_v  <= r_issuing;
            r_p1_v  <= r_p0_v;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            if (r_issuing && r_cnt == r_last) begin
                r_issuing <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GOAL_TOL:  r_goal_tol <= i_cfg_data;
                    CFG_STOP_DIST: r_stop     <= i_cfg_data;
                    CFG_SLOW_DIST: r_slow     <= i_cfg_data;
                    CFG_LOOKAHEAD: r_la       <= i_cfg_data;
                    CFG_FWD_GAIN:  r_fgain    <= i_cfg_data;
                    CFG_TURN_GAIN: r_tgain    <= i_cfg_data;
                    CFG_FWD_LIMIT: r_flim     <= i_cfg_data;
                    CFG_TURN_LIM:  r_tlim     <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_operation)
                            OP_CLEAR: r_len <= '0;
                            OP_APPEND: begin
                                if (r_len < LW'(PATH_DEPTH)) r_len <= r_len + 1'b1;
                            end
                            OP_CMD: begin
                                if (r_len == '0) o_valid <= 1'b1;
                                else r_issuing <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK: begin
                    if ({17'b0, w_tol2} >= r_gd2 || r_obs < r_stop) o_valid <= 1'b1;
                    else r_issuing <= 1'b1;
                end
                ST_SCAN1: if (w_pipe_empty) r_issuing <= 1'b1;
                ST_OUT:   o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_issuing) r_cnt <= r_cnt + 1'b1;
        r_p0_idx <= r_cnt;
        r_p1_idx <= r_p0_idx;
        r_p2_idx <= r_p1_idx;
        r_p3_idx <= r_p2_idx;
        r_dx1    <= w_dx;
        r_dy1    <= w_dy;
        r_sqx    <= w_sqx[47:0];
        r_sqy    <= w_sqy[47:0];
        r_dx2    <= r_dx1;
        r_dy2    <= r_dy1;
        r_d2     <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_dx3    <= r_dx2;
        r_dy3    <= r_dy2;

        if ((r_state == ST_SQRT_T || r_state == ST_SQRT_G) && r_sq_bit != '0) begin
            if (r_sq_v >= w_sq_t) begin
                r_sq_v <= r_sq_v - w_sq_t;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end

        case (r_state)
            ST_IDLE: begin
                r_rx    <= i_robot_x;
                r_ry    <= i_robot_y;
                r_head  <= i_robot_heading;
                r_obs   <= i_obstacle_distance;
                r_cnt   <= w_last_idx;
                r_last  <= w_last_idx;
                o_forward_speed  <= '0;
                o_turn_rate      <= '0;
                o_goal_reached   <= 1'b0;
                o_motion_blocked <= 1'b1;
            end
            ST_GOAL: begin
                if (r_p3_v) begin
                    r_gd2 <= r_d2;
                    r_gdx <= r_dx3;
                    r_gdy <= r_dy3;
                end
            end
            ST_CHECK: begin
                o_forward_speed  <= '0;
                o_turn_rate      <= '0;
                o_goal_reached   <= ({17'b0, w_tol2} >= r_gd2);
                o_motion_blocked <= !({17'b0, w_tol2} >= r_gd2);
                r_la2  <= w_la2;
                r_cnt  <= '0;
                r_last <= w_last_idx;
            end
            ST_SCAN1: begin
                if (r_p3_v && (r_p3_idx == '0 || r_d2 < r_best)) begin
                    r_best    <= r_d2;
                    r_closest <= r_p3_idx;
                end
                // second scan starts at the closest point once the first has drained
                if (w_pipe_empty) r_cnt <= r_closest;
                r_found <= 1'b0;
            end
            ST_SCAN2: begin
                if (r_p3_v && !r_found && r_d2 >= {17'b0, r_la2}) begin
                    r_found <= 1'b1;
                    r_td2   <= r_d2;
                    r_tdx   <= r_dx3;
                    r_tdy   <= r_dy3;
                end
                if (w_pipe_empty) begin
                    // no point far enough: steer at the last point
                    if (!r_found) begin
                        r_tdx <= r_gdx;
                        r_tdy <= r_gdy;
                    end
                    r_sq_v   <= {1'b0, r_found ? r_td2 : r_gd2};
                    r_sq_r   <= '0;
                    r_sq_bit <= SQRT_TOP;
                end
            end
            ST_SQRT_T: begin
                if (r_sq_bit == '0) begin
                    r_tdist  <= r_sq_r[24:0];
                    r_sq_v   <= {1'b0, r_gd2};
                    r_sq_r   <= '0;
                    r_sq_bit <= SQRT_TOP;
                end
            end
            ST_SQRT_G: begin
                r_gdist <= r_sq_r[24:0];
                r_zero  <= (r_tdx == '0 && r_tdy == '0);
            end
            ST_BEAR: begin
                r_err <= 26'(w_bear) - (26'(r_head) <<< 7);
            end
            ST_ERR: begin
                r_err13 <= w_r64[17:0];
                r_s1    <= w_s1[40:8];
            end
            ST_COSLD: begin
                if (w_turn > w_tl) r_turn <= w_tl[15:0];
                else if (w_turn < -w_tl) r_turn <= 16'(-w_tl);
                else r_turn <= w_turn[15:0];
                r_span <= w_span;
                r_num  <= (w_diff > w_span) ? w_span : w_diff;
            end
            ST_COS: begin
                if (c_x < 0) r_cos <= '0;
                else if (c_x > ONE_Q30) r_cos <= ONE_Q30[30:0];
                else r_cos <= c_x[30:0];
            end
            ST_MULC: begin
                if (r_err13 > 18'sd8192 || r_err13 < -18'sd8192) r_s <= '0;
                else r_s <= w_sc[62:30];
            end
            ST_SLOW: begin
                r_dq   <= w_prod;
                r_drem <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                r_dq   <= w_dq_next;
                r_drem <= w_rem_next;
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 6'd48) r_s <= w_dq_next[32:0];
            end
            ST_OUT: begin
                o_forward_speed  <= (r_s > {17'b0, r_flim}) ? r_flim : r_s[15:0];
                o_turn_rate      <= r_turn;
                o_goal_reached   <= 1'b0;
                o_motion_blocked <= 1'b0;
            end
            default: ;
        endcase
    end

    `LPTC_ASSERT_IMP(a_len_bound, 1'b1, r_len <= LW'(PATH_DEPTH))
    `LPTC_ASSERT_IMP(a_flags_excl, o_valid, !(o_goal_reached && o_motion_blocked))
    `LPTC_ASSERT_IMP(a_reached_still, o_valid && o_goal_reached, o_forward_speed == '0 && o_turn_rate == '0)
    `LPTC_ASSERT_NXT(a_empty_blocks, w_accept && i_operation == OP_CMD && r_len == '0, o_valid && o_motion_blocked)

endmodule

// ===== tb/lookahead_path_tracking_controller_checker.sv =====
// Checker: watches the command and config channels, predicts drive commands, compares results.
`timescale 1ns / 1ps
module lookahead_path_tracking_controller_checker
    import lptc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_robot_x,
    input  logic signed [23:0] i_robot_y,
    input  logic signed [15:0] i_robot_heading,
    input  logic [15:0]        i_obstacle_distance,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic [15:0]        o_forward_speed,
    input  logic signed [15:0] o_turn_rate,
    input  logic               o_goal_reached,
    input  logic               o_motion_blocked,
    output int                 fail_count,
    output int                 pending_count,
    output int                 command_count
);
    localparam int DEPTH = 128;
    localparam int STEPS = 16;
    localparam longint PI_20 = 3294199;
    localparam longint HALF_PI_20 = 1647099;
    localparam longint TWO_PI_20 = 6588398;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [15:0] turn;
        logic               reached;
        logic               blocked;
    } t_drive_cmd;

    const longint arctan_lut [STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    longint unsigned goal_tol, stop_dist, slow_dist, look_range;
    longint unsigned fwd_gain, turn_gain, fwd_limit, turn_lim;
    logic signed [23:0] way_x [DEPTH];
    logic signed [23:0] way_y [DEPTH];
    int unsigned way_count;
    t_drive_cmd cmd_queue [$];

    assign pending_count = cmd_queue.size();

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned range_sq(int k, longint rx, longint ry);
        longint dx, dy;
        dx = longint'(way_x[k]) - rx;
        dy = longint'(way_y[k]) - ry;
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // vectoring run, angle in 2^-20 rad
    function automatic longint target_bearing(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI_20;
            end else begin
                x = -y; y = t; z = -HALF_PI_20;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += arctan_lut[i];
            end else begin
                x = x - ys; y = y + xs; z -= arctan_lut[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned cos_q30(longint z);
        longint x, y, xs, ys;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= arctan_lut[i];
            end else begin
                x = x + ys; y = y - xs; z += arctan_lut[i];
            end
        end
        if (x < 0) x = 0;
        if (x > 64'sd1073741824) x = 1073741824;
        return longint'(x);
    endfunction

    function automatic t_drive_cmd steer_command(longint rx, longint ry, longint head,
                                                 longint unsigned obs);
        t_drive_cmd c;
        longint unsigned gd2, best, d2, tdist, gdist, near_dist, s, span, num;
        longint err, err13, turn, tl;
        int closest, target;
        c = '0;
        if (way_count == 0) begin
            c.blocked = 1'b1;
            return c;
        end
        gd2 = range_sq(way_count - 1, rx, ry);
        if (gd2 <= goal_tol * goal_tol) begin
            c.reached = 1'b1;
            return c;
        end
        if (obs < stop_dist) begin
            c.blocked = 1'b1;
            return c;
        end
        closest = 0;
        best = range_sq(0, rx, ry);
        for (int k = 1; k < way_count; k++) begin
            d2 = range_sq(k, rx, ry);
            if (d2 < best) begin
                best = d2;
                closest = k;
            end
        end
        target = way_count - 1;
        for (int k = closest; k < way_count; k++) begin
            if (range_sq(k, rx, ry) >= look_range * look_range) begin
                target = k;
                break;
            end
        end
        tdist = floor_sqrt(range_sq(target, rx, ry));
        gdist = floor_sqrt(gd2);
        err = target_bearing(longint'(way_x[target]) - rx, longint'(way_y[target]) - ry)
              - head * 128;
        while (err > PI_20) err -= TWO_PI_20;
        while (err <= -PI_20) err += TWO_PI_20;
        err13 = (err + 64) >>> 7;
        near_dist = (tdist < gdist) ? tdist : gdist;
        s = (fwd_gain * near_dist) >> 8;
        if (err13 > 8192 || err13 < -8192) s = 0;
        else s = (s * cos_q30(err13 * 128)) >> 30;
        if (obs < slow_dist) begin
            span = (slow_dist > stop_dist + 10) ? slow_dist - stop_dist : 10;
            num = obs - stop_dist;
            if (num > span) num = span;
            s = s * num / span;
        end
        if (s > fwd_limit) s = fwd_limit;
        turn = (longint'(turn_gain) * err13 + 1024) >>> 11;
        tl = longint'(turn_lim);
        if (turn > tl) turn = tl;
        if (turn < -tl) turn = -tl;
        c.speed = s[15:0];
        c.turn = turn[15:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_drive_cmd want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            goal_tol <= 205; stop_dist <= 307; slow_dist <= 819; look_range <= 512;
            fwd_gain <= 128; turn_gain <= 256; fwd_limit <= 512; turn_lim <= 1024;
            way_count = 0;
            cmd_queue.delete();
            fail_count <= 0;
            command_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GOAL_TOL:  goal_tol <= i_cfg_data;
                    CFG_STOP_DIST: stop_dist <= i_cfg_data;
                    CFG_SLOW_DIST: slow_dist <= i_cfg_data;
                    CFG_LOOKAHEAD: look_range <= i_cfg_data;
                    CFG_FWD_GAIN:  fwd_gain <= i_cfg_data;
                    CFG_TURN_GAIN: turn_gain <= i_cfg_data;
                    CFG_FWD_LIMIT: fwd_limit <= i_cfg_data;
                    CFG_TURN_LIM:  turn_lim <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (cmd_queue.size() == 0) begin
                    $error("unexpected drive command transaction");
                    errs++;
                end else begin
                    want = cmd_queue.pop_front();
                    if (o_forward_speed !== want.speed) begin
                        $error("forward_speed exp %0d got %0d", want.speed, o_forward_speed);
                        errs++;
                    end
                    if (o_turn_rate !== want.turn) begin
                        $error("turn_rate exp %0d got %0d", want.turn, o_turn_rate);
                        errs++;
                    end
                    if (o_goal_reached !== want.reached) begin
                        $error("goal_reached exp %0d got %0d", want.reached, o_goal_reached);
                        errs++;
                    end
                    if (o_motion_blocked !== want.blocked) begin
                        $error("motion_blocked exp %0d got %0d", want.blocked,
                               o_motion_blocked);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (i_start && !o_busy) begin
                case (i_operation)
                    OP_CLEAR: way_count = 0;
                    OP_APPEND: begin
                        if (way_count < DEPTH) begin
                            way_x[way_count] = i_point_x;
                            way_y[way_count] = i_point_y;
                            way_count++;
                        end
                    end
                    OP_CMD: begin
                        cmd_queue.push_back(steer_command(i_robot_x, i_robot_y,
                                                          i_robot_heading, i_obstacle_distance));
                        command_count <= command_count + 1;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/lookahead_path_tracking_controller_tb.sv =====
// Testbench top: clock, reset, stimulus for path, command and config channels, verdict.
`timescale 1ns / 1ps
module lookahead_path_tracking_controller_tb;
    import lptc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_operation = OP_CLEAR;
    logic signed [23:0] i_point_x = '0;
    logic signed [23:0] i_point_y = '0;
    logic signed [23:0] i_robot_x = '0;
    logic signed [23:0] i_robot_y = '0;
    logic signed [15:0] i_robot_heading = '0;
    logic [15:0]        i_obstacle_distance = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = CFG_GOAL_TOL;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [15:0]        o_forward_speed;
    logic signed [15:0] o_turn_rate;
    logic               o_goal_reached;
    logic               o_motion_blocked;

    int fail_count, pending_count, command_count;
    int item_count = 0;
    int gap_mode = 0;
    logic [15:0] stop_now = 16'd307;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lookahead_path_tracking_controller dut (.*);

    lookahead_path_tracking_controller_checker chk (.*);

    // a run of items either waits a random idle gap before each next item or not at all
    function automatic int draw_gap();
        return (gap_mode == 0) ? 0 : $urandom_range(17, 0);
    endfunction

    task automatic send_item(logic [1:0] op, logic [23:0] px, logic [23:0] py,
                             logic [23:0] rx, logic [23:0] ry, logic [15:0] hd,
                             logic [15:0] obs);
        int gap;
        gap = draw_gap();
        i_start <= 1'b1;
        i_operation <= op;
        i_point_x <= px;
        i_point_y <= py;
        i_robot_x <= rx;
        i_robot_y <= ry;
        i_robot_heading <= hd;
        i_obstacle_distance <= obs;
        do @(posedge i_clk); while (o_busy);
        item_count++;
        if ($urandom_range(40, 0) == 0) gap_mode = $urandom_range(2, 0);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic append_point(logic [23:0] px, logic [23:0] py);
        send_item(OP_APPEND, px, py, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic ask_drive(logic [23:0] rx, logic [23:0] ry, logic [15:0] hd,
                             logic [15:0] obs);
        send_item(OP_CMD, $urandom, $urandom, rx, ry, hd, obs);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_STOP_DIST) stop_now = val;
    endtask

    task automatic load_regs(logic [15:0] tol, logic [15:0] stp, logic [15:0] slw,
                             logic [15:0] look, logic [15:0] fg, logic [15:0] tg,
                             logic [15:0] fl, logic [15:0] tlim);
        drain();
        write_reg(CFG_GOAL_TOL, tol);
        write_reg(CFG_STOP_DIST, stp);
        write_reg(CFG_SLOW_DIST, slw);
        write_reg(CFG_LOOKAHEAD, look);
        write_reg(CFG_FWD_GAIN, fg);
        write_reg(CFG_TURN_GAIN, tg);
        write_reg(CFG_FWD_LIMIT, fl);
        write_reg(CFG_TURN_LIM, tlim);
    endtask

    // one trip: clear, lay a path of waypoints, then drive along it
    task automatic run_trip();
        logic signed [23:0] bx, by, cx, cy, lx, ly;
        logic signed [23:0] px [$];
        logic signed [23:0] py [$];
        int n, k, j, span;
        span = ($urandom_range(3, 0) == 0) ? 20000 : 2500;
        bx = $signed($urandom_range(200000, 0)) - 100000;
        by = $signed($urandom_range(200000, 0)) - 100000;
        n = ($urandom_range(30, 0) == 0) ? $urandom_range(132, 100) : $urandom_range(12, 1);
        send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        cx = bx;
        cy = by;
        for (int i = 0; i < n; i++) begin
            cx += $signed($urandom_range(2 * span, 0)) - span;
            cy += $signed($urandom_range(2 * span, 0)) - span;
            px.push_back(cx);
            py.push_back(cy);
            append_point(cx, cy);
        end
        lx = (n > 128) ? px[127] : cx;
        ly = (n > 128) ? py[127] : cy;
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) begin
            j = $urandom_range(px.size() - 1, 0);
            case ($urandom_range(7, 0))
                0: ask_drive(lx, ly, $urandom, $urandom);
                1: ask_drive(lx + $signed($urandom_range(400, 0)) - 200, ly,
                             $signed($urandom_range(51472, 0)) - 25736, $urandom);
                default: ask_drive(px[j] + $signed($urandom_range(2 * span, 0)) - span,
                                   py[j] + $signed($urandom_range(2 * span, 0)) - span,
                                   $signed($urandom_range(51472, 0)) - 25736,
                                   ($urandom_range(1, 0) == 0) ?
                                   16'(stop_now + $urandom_range(1200, 0)) :
                                   16'($urandom));
            endcase
        end
    endtask

    task automatic random_phase(int n_items);
        int stop_at;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            if ($urandom_range(9, 0) == 0)
                send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                run_trip();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty path, unused code, field extremes, goal, near obstacle, full path
        ask_drive(0, 0, 0, 16'hFFFF);
        send_item(2'd3, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0);
        append_point(24'h800000, 24'h7FFFFF);
        append_point(24'h7FFFFF, 24'h800000);
        ask_drive(24'h800000, 24'h800000, 16'h8000, 16'hFFFF);
        ask_drive(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h0000);
        ask_drive(24'h7FFFFF, 24'h800000 + 24'd100, 16'sd25736, 16'd500);
        ask_drive(24'h7FFFFF - 24'd2000, 24'h800000, -16'sd25736, 16'd310);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        append_point(1000, 0);
        append_point(2000, 0);
        ask_drive(1000, 0, 0, 16'd5000);
        ask_drive(2000, 0, 0, 16'd5000);
        ask_drive(-3000, 0, 0, 16'd5000);
        ask_drive(0, 0, 16'sd20000, 16'd5000);
        for (int i = 0; i < 130; i++) append_point(i * 300, i * 100);
        ask_drive(0, 0, 0, 16'd600);
        ask_drive(0, 0, 0, 16'd100);
        ask_drive(20000, 6000, -16'sd10000, 16'd800);

        random_phase(400);
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF);
        random_phase(150);
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(250);
        load_regs(16'd50, 16'd200, 16'd205, 16'd3000, 16'd2000, 16'd4000,
                  16'hFFFF, 16'h7FFF);
        random_phase(400);
        load_regs($urandom_range(400, 0), $urandom_range(600, 0), $urandom_range(2000, 0),
                  $urandom_range(5000, 0), $urandom, $urandom, $urandom, $urandom);
        random_phase(400);
        drain();

        $display("covered %0d items, %0d drive commands checked, over five register settings",
                 item_count, command_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end
endmodule
